FILE: rtl/spid_pkg.sv
// ----------------------------------------------------------------------------
// spid_pkg: shared types and constants of the sampled speed PID
// Holds the fixed widths, register indexes, FSM states and the 32-bit
// saturation helper used by the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package spid_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned MUL_OP_W  = 33;
    localparam int unsigned ACC_W     = 2 * MUL_OP_W;
    // |rotation difference| * 1000 stays below 2^42
    localparam int unsigned NUM_W     = 42;
    localparam int unsigned CNT_W     = $clog2(NUM_W + 1);
    localparam int unsigned MS_PER_S  = 1000;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TIME_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE   = 3'd5;

    localparam logic [15:0] SAMPLE_TIME_RST  = 16'd500;
    localparam logic [7:0]  OUTPUT_SCALE_RST = 8'd4;

    typedef logic signed [DATA_W-1:0]   s32_t;
    typedef logic signed [MUL_OP_W-1:0] mul_op_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    localparam s32_t S32_MAX = 32'sh7FFF_FFFF;
    localparam s32_t S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ABS,
        S_DIFF,
        S_SCALE,
        S_DIV_START,
        S_DIV_WAIT,
        S_ERR,
        S_MUL_I,
        S_MUL_P,
        S_MUL_D,
        S_ACC,
        S_SAT,
        S_MUL_S,
        S_DONE
    } state_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic s32_t sat32(input acc_t v);
        s32_t r;
        if ((&v[ACC_W-1:DATA_W-1]) || (~|v[ACC_W-1:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = S32_MIN;
        end else begin
            r = S32_MAX;
        end
        return r;
    endfunction

endpackage

FILE: rtl/sampled_speed_pid.sv
// ----------------------------------------------------------------------------
// sampled_speed_pid: speed PID controller with derivative on measurement
// Turns a millisecond timestamp and a cumulative rotation count into a
// saturated Q16.16 drive adjustment and the measured wheel speed.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer per sample, tdata = {rotations, now_ms}.
//   Result stream (m_*): exactly one transfer per input, tdata =
//   {speed, drive_delta}, tuser = updated.
//   Configuration: cfg_we / cfg_index / cfg_data write one register per cycle,
//   only while no sample is in flight.
//   Sequence: a sample arriving before the sample time has run out goes
//   straight to the final step. An update runs through the 42-step restoring
//   divider that forms |rotation difference| * 1000 / elapsed; the
//   five gain and scale products share one registered multiplier.
//   Flow: one sample at a time; s_tready is high only while the sequencer
//   is idle, so the next sample waits until the last result is loaded.
//   Stall: the result sits in an output register; the sequencer may accept
//   and work on the next sample meanwhile and holds at its final step until
//   the register is free. Controller state commits together with the result.
//   Reset: aresetn (synchronous, active low) clears the controller state,
//   returns the registers to their defaults and empties the output register.
// ----------------------------------------------------------------------------
module sampled_speed_pid #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] now_ms, [63:32] rotations

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] drive_delta, [63:32] speed
    output logic [0:0]  m_tuser,    // [0] updated

    input  logic                               cfg_we,
    input  logic [spid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);

    // ---------------- configuration registers ----------------
    spid_pkg::s32_t target_speed_reg;
    logic [15:0]    sample_time_ms_reg;
    spid_pkg::s32_t gain_p_reg;
    spid_pkg::s32_t gain_i_reg;
    spid_pkg::s32_t gain_d_reg;
    logic [7:0]     output_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_speed_reg   <= '0;
            sample_time_ms_reg <= spid_pkg::SAMPLE_TIME_RST;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            output_scale_reg   <= spid_pkg::OUTPUT_SCALE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                spid_pkg::REG_TARGET_SPEED:   target_speed_reg   <= cfg_data;
                spid_pkg::REG_SAMPLE_TIME_MS: sample_time_ms_reg <= cfg_data[15:0];
                spid_pkg::REG_GAIN_P:         gain_p_reg         <= cfg_data;
                spid_pkg::REG_GAIN_I:         gain_i_reg         <= cfg_data;
                spid_pkg::REG_GAIN_D:         gain_d_reg         <= cfg_data;
                spid_pkg::REG_OUTPUT_SCALE:   output_scale_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- controller state ----------------
    logic [31:0]    last_update_ms_reg;
    spid_pkg::s32_t last_rotations_reg;
    spid_pkg::s32_t integral_sum_reg;
    spid_pkg::s32_t previous_speed_reg;

    // ---------------- sequencer ----------------
    spid_pkg::state_t state_reg, state_next;

    logic                         s_xfer;
    logic                         out_free;
    logic                         load_out;
    logic                         mul_en;
    spid_pkg::mul_op_t            mul_a;
    spid_pkg::mul_op_t            mul_b;
    spid_pkg::acc_t               mul_prod;
    logic                         div_start;
    spid_pkg::div_status_t        div_status;
    logic [spid_pkg::NUM_W-1:0]   div_quo;

    // sample-time check on the incoming transfer
    logic [31:0]    elapsed_now;
    logic [15:0]    min_time;
    logic           skip_now;

    // per-sample working registers
    logic [31:0]    now_reg;
    spid_pkg::s32_t rot_reg;
    logic [31:0]    elapsed_reg;
    logic           skip_reg;
    logic [31:0]    rot_mag_reg;
    logic [31:0]    diff_mag_reg;
    logic           diff_neg_reg;
    spid_pkg::s32_t speed_reg;
    spid_pkg::s32_t err_reg;
    spid_pkg::s32_t dspd_reg;
    spid_pkg::s32_t ival_reg;
    spid_pkg::acc_t acc_reg;
    spid_pkg::s32_t sum_reg;

    // output register
    logic           m_tvalid_reg;
    spid_pkg::s32_t pwm_out_reg;
    spid_pkg::s32_t speed_out_reg;
    logic           updated_out_reg;

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spid_pkg::S_IDLE: begin
                if (s_xfer) begin
                    state_next = skip_now ? spid_pkg::S_DONE : spid_pkg::S_ABS;
                end
            end
            spid_pkg::S_ABS:       state_next = spid_pkg::S_DIFF;
            spid_pkg::S_DIFF:      state_next = spid_pkg::S_SCALE;
            spid_pkg::S_SCALE:     state_next = spid_pkg::S_DIV_START;
            spid_pkg::S_DIV_START: state_next = spid_pkg::S_DIV_WAIT;
            spid_pkg::S_DIV_WAIT: begin
                if (div_status.done) begin
                    state_next = spid_pkg::S_ERR;
                end
            end
            spid_pkg::S_ERR:       state_next = spid_pkg::S_MUL_I;
            spid_pkg::S_MUL_I:     state_next = spid_pkg::S_MUL_P;
            spid_pkg::S_MUL_P:     state_next = spid_pkg::S_MUL_D;
            spid_pkg::S_MUL_D:     state_next = spid_pkg::S_ACC;
            spid_pkg::S_ACC:       state_next = spid_pkg::S_SAT;
            spid_pkg::S_SAT:       state_next = spid_pkg::S_MUL_S;
            spid_pkg::S_MUL_S:     state_next = spid_pkg::S_DONE;
            spid_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = spid_pkg::S_IDLE;
                end
            end
            default:               state_next = spid_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operand select, divider start, result load
    always_comb begin
        s_tready  = 1'b0;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            spid_pkg::S_IDLE:      s_tready = 1'b1;
            spid_pkg::S_SCALE: begin
                mul_en = 1'b1;
                mul_a  = spid_pkg::mul_op_t'(diff_mag_reg);
                mul_b  = spid_pkg::mul_op_t'(spid_pkg::MS_PER_S);
            end
            spid_pkg::S_DIV_START: div_start = 1'b1;
            spid_pkg::S_MUL_I: begin
                mul_en = 1'b1;
                mul_a  = spid_pkg::mul_op_t'(gain_i_reg);
                mul_b  = spid_pkg::mul_op_t'(err_reg);
            end
            spid_pkg::S_MUL_P: begin
                mul_en = 1'b1;
                mul_a  = spid_pkg::mul_op_t'(gain_p_reg);
                mul_b  = spid_pkg::mul_op_t'(err_reg);
            end
            spid_pkg::S_MUL_D: begin
                mul_en = 1'b1;
                mul_a  = spid_pkg::mul_op_t'(gain_d_reg);
                mul_b  = spid_pkg::mul_op_t'(dspd_reg);
            end
            spid_pkg::S_MUL_S: begin
                mul_en = 1'b1;
                mul_a  = spid_pkg::mul_op_t'(sum_reg);
                mul_b  = spid_pkg::mul_op_t'(output_scale_reg);
            end
            spid_pkg::S_DONE:      load_out = out_free;
            default: ;
        endcase
    end

    // sample-time check on the incoming transfer (elapsed wraps modulo 2^32)
    always_comb begin
        elapsed_now = s_tdata[31:0] - last_update_ms_reg;
        min_time    = (sample_time_ms_reg == 16'd0) ? 16'd1 : sample_time_ms_reg;
        skip_now    = elapsed_now < {16'd0, min_time};
    end

    // datapath arithmetic feeding the working registers
    logic [33:0]    diff_fwd;
    logic [33:0]    diff_rev;
    logic [31:0]    rot_abs;
    logic           quo_big_pos;
    logic           quo_big_neg;
    spid_pkg::s32_t speed_calc;
    spid_pkg::acc_t prod_shr;

    always_comb begin
        // most negative count saturates to the largest positive magnitude
        if (!rot_reg[31]) begin
            rot_abs = rot_reg;
        end else if (rot_reg == spid_pkg::S32_MIN) begin
            rot_abs = spid_pkg::S32_MAX;
        end else begin
            rot_abs = 32'(-rot_reg);
        end

        diff_fwd = {2'b00, rot_mag_reg} - {{2{last_rotations_reg[31]}}, last_rotations_reg};
        diff_rev = {{2{last_rotations_reg[31]}}, last_rotations_reg} - {2'b00, rot_mag_reg};

        // quotient magnitude to signed speed with saturation
        quo_big_pos = |div_quo[spid_pkg::NUM_W-1:31];
        quo_big_neg = (|div_quo[spid_pkg::NUM_W-1:32]) || (div_quo[31] && (|div_quo[30:0]));
        if (diff_neg_reg) begin
            speed_calc = quo_big_neg ? spid_pkg::S32_MIN : 32'(~div_quo[31:0] + 32'd1);
        end else begin
            speed_calc = quo_big_pos ? spid_pkg::S32_MAX : div_quo[31:0];
        end

        // floor(product / 2^FRAC_BITS)
        prod_shr = mul_prod >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spid_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // working registers: advance one step per sequencer state
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            now_reg     <= s_tdata[31:0];
            rot_reg     <= s_tdata[63:32];
            elapsed_reg <= elapsed_now;
            skip_reg    <= skip_now;
        end
        if (state_reg == spid_pkg::S_ABS) begin
            rot_mag_reg <= rot_abs;
        end
        if (state_reg == spid_pkg::S_DIFF) begin
            diff_neg_reg <= diff_fwd[33];
            diff_mag_reg <= diff_fwd[33] ? diff_rev[31:0] : diff_fwd[31:0];
        end
        if (state_reg == spid_pkg::S_DIV_WAIT && div_status.done) begin
            speed_reg <= speed_calc;
        end
        if (state_reg == spid_pkg::S_ERR) begin
            err_reg  <= spid_pkg::sat32(spid_pkg::acc_t'(target_speed_reg)
                                        - spid_pkg::acc_t'(speed_reg));
            dspd_reg <= spid_pkg::sat32(spid_pkg::acc_t'(speed_reg)
                                        - spid_pkg::acc_t'(previous_speed_reg));
        end
        if (state_reg == spid_pkg::S_MUL_P) begin
            // integral product is ready here
            ival_reg <= spid_pkg::sat32(spid_pkg::acc_t'(integral_sum_reg)
                                        + spid_pkg::acc_t'(spid_pkg::sat32(prod_shr)));
        end
        if (state_reg == spid_pkg::S_MUL_D) begin
            acc_reg <= prod_shr + spid_pkg::acc_t'(ival_reg);
        end
        if (state_reg == spid_pkg::S_ACC) begin
            acc_reg <= acc_reg - prod_shr;
        end
        if (state_reg == spid_pkg::S_SAT) begin
            sum_reg <= spid_pkg::sat32(acc_reg);
        end
    end

    // output register and state commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg       <= 1'b0;
            last_update_ms_reg <= '0;
            last_rotations_reg <= '0;
            integral_sum_reg   <= '0;
            previous_speed_reg <= '0;
        end else begin
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (load_out && !skip_reg) begin
                last_update_ms_reg <= now_reg;
                last_rotations_reg <= rot_reg;
                integral_sum_reg   <= ival_reg;
                previous_speed_reg <= speed_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            pwm_out_reg     <= skip_reg ? '0 : spid_pkg::sat32(mul_prod);
            speed_out_reg   <= skip_reg ? previous_speed_reg : speed_reg;
            updated_out_reg <= !skip_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {speed_out_reg, pwm_out_reg};
    assign m_tuser[0] = updated_out_reg;

    // ---------------- arithmetic units ----------------
    spid_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    spid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_prod[spid_pkg::NUM_W-1:0]),
        .divisor  (elapsed_reg),
        .status   (div_status),
        .quotient (div_quo)
    );

`ifndef SYNTHESIS
    // a held result always agrees with the committed speed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (previous_speed_reg == speed_out_reg))
        else $error("held speed differs from committed speed");

    // a sample without update drives no adjustment
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !updated_out_reg) |-> (pwm_out_reg == '0))
        else $error("nonzero drive adjustment without update");

    // the divider only runs while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == spid_pkg::S_DIV_WAIT))
        else $error("divider busy outside divide step");

    // an update reaches the final step only through the scale product
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spid_pkg::S_DONE && !skip_reg) |->
            ($past(state_reg) == spid_pkg::S_MUL_S || $past(state_reg) == spid_pkg::S_DONE))
        else $error("update finished without scale product");
`endif

endmodule

FILE: rtl/spid_mul.sv
// ----------------------------------------------------------------------------
// spid_mul: shared signed multiplier
// One 33 x 33 signed product per cycle, registered on the output and held
// until the next issue.
// ----------------------------------------------------------------------------
module spid_mul (
    input  logic              aclk,
    input  logic              en,
    input  spid_pkg::mul_op_t op_a,
    input  spid_pkg::mul_op_t op_b,
    output spid_pkg::acc_t    prod
);

    spid_pkg::acc_t prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/spid_div.sv
// ----------------------------------------------------------------------------
// spid_div: radix-2 restoring divider
// Unsigned NUM_W by 32-bit divide, one quotient bit per cycle; done pulses
// for one cycle after the last step with the quotient held.
// ----------------------------------------------------------------------------
module spid_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [spid_pkg::NUM_W-1:0]      dividend,
    input  logic [spid_pkg::DATA_W-1:0]     divisor,
    output spid_pkg::div_status_t           status,
    output logic [spid_pkg::NUM_W-1:0]      quotient
);

    logic [spid_pkg::NUM_W-1:0]  quo_reg;
    logic [spid_pkg::DATA_W-1:0] rem_reg;
    logic [spid_pkg::DATA_W-1:0] dvs_reg;
    logic [spid_pkg::CNT_W-1:0]  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [spid_pkg::DATA_W:0]   shifted;
    logic [spid_pkg::DATA_W:0]   trial;
    logic                        fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[spid_pkg::NUM_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = ~trial[spid_pkg::DATA_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= spid_pkg::CNT_W'(spid_pkg::NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == spid_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            // shift in next dividend bit, subtract when it fits
            quo_reg <= {quo_reg[spid_pkg::NUM_W-2:0], fits};
            rem_reg <= fits ? trial[spid_pkg::DATA_W-1:0] : shifted[spid_pkg::DATA_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

FILE: sim/sampled_speed_pid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_speed_pid_tb: self-checking bench for the sampled speed PID
// Streams timestamp/rotation samples into the controller, mirrors the
// controller state and register file in a local predictor and compares every
// result transfer (drive_delta, speed, updated) with the predicted one. Runs
// directed boundary samples first, then random traffic under several
// backpressure and idle profiles with a fresh register setting per half.
// ----------------------------------------------------------------------------
module sampled_speed_pid_tb;

    localparam int          FRAC_BITS   = 16;
    localparam int          QUIET_LIMIT = 20000;  // cycles without any transfer
    localparam int          DRAIN_WAIT  = 64;     // wait before the verdict
    localparam int          REPORT_CAP  = 200;    // keep the log readable

    typedef struct {
        logic signed [31:0] pwm;
        logic signed [31:0] speed;
        logic               updated;
    } pid_result_t;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [63:0]                    s_tdata   = '0;  // [31:0] now_ms, [63:32] rotations
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [63:0]                    m_tdata;         // [31:0] drive_delta, [63:32] speed
    logic [0:0]                     m_tuser;         // [0] updated
    logic                           cfg_we    = 1'b0;
    logic [spid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                    cfg_data  = '0;

    // ------------------------------------------------------------------------
    // Predictor copy of the register file and the controller state
    // ------------------------------------------------------------------------
    spid_pkg::s32_t     tgt_speed  = '0;
    logic [15:0]        sample_ms  = spid_pkg::SAMPLE_TIME_RST;
    spid_pkg::s32_t     kp         = '0;
    spid_pkg::s32_t     ki         = '0;
    spid_pkg::s32_t     kd         = '0;
    logic [7:0]         out_scale  = spid_pkg::OUTPUT_SCALE_RST;

    logic [31:0]        last_update_ms = '0;
    spid_pkg::s32_t     last_rot       = '0;
    spid_pkg::s32_t     integral_acc   = '0;
    spid_pkg::s32_t     prev_speed     = '0;

    pid_result_t        pending_results[$];
    pid_result_t        oldest;

    // Stimulus cursors: the last sample sent, used to build plausible streams
    logic [31:0]        sent_ms  = '0;
    logic [31:0]        sent_rot = '0;

    int unsigned        send_idle_pct  = 0;
    int unsigned        stall_pct      = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles   = 0;

    sampled_speed_pid #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Arithmetic of the controller, in 64-bit signed terms
    // ------------------------------------------------------------------------
    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Fixed-point product, floored (arithmetic shift rounds toward -inf)
    function automatic longint q_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return p >>> FRAC_BITS;
    endfunction

    // Advance the mirrored controller by one sample and return its result
    function automatic pid_result_t compute_pid_step(input logic [31:0] now_ms,
                                                     input spid_pkg::s32_t rot);
        pid_result_t r;
        logic [31:0] elapsed;
        logic [31:0] min_ms;
        longint      mag, spd, err, ival, dspd, sum, pwm;

        elapsed = now_ms - last_update_ms;
        // a zero sample time behaves as one millisecond
        min_ms  = (sample_ms == 16'd0) ? 32'd1 : {16'd0, sample_ms};
        if (elapsed < min_ms) begin
            r.pwm     = '0;
            r.speed   = prev_speed;
            r.updated = 1'b0;
            return r;
        end

        // |most negative| clamps to the positive limit
        mag  = clamp_s32((rot < 0) ? -longint'(rot) : longint'(rot));
        spd  = clamp_s32(((mag - longint'(last_rot)) * 1000)
                         / longint'({32'd0, elapsed}));
        err  = clamp_s32(longint'(tgt_speed) - spd);
        ival = clamp_s32(longint'(integral_acc) + clamp_s32(q_mul(longint'(ki), err)));
        dspd = clamp_s32(spd - longint'(prev_speed));
        sum  = clamp_s32(q_mul(longint'(kp), err) + ival - q_mul(longint'(kd), dspd));
        pwm  = clamp_s32(sum * longint'({56'd0, out_scale}));

        // store the raw signed rotations, not the magnitude
        integral_acc   = ival[31:0];
        prev_speed     = spd[31:0];
        last_update_ms = now_ms;
        last_rot       = rot;

        r.pwm     = pwm[31:0];
        r.speed   = spd[31:0];
        r.updated = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP) begin
            $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, compare each transfer with the oldest entry
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result transfer with nothing pending", m_tdata[31:0], '0);
            end else begin
                oldest = pending_results.pop_front();
                if (m_tdata[31:0] !== oldest.pwm) begin
                    note_mismatch("drive_delta", m_tdata[31:0], oldest.pwm);
                end
                if (m_tdata[63:32] !== oldest.speed) begin
                    note_mismatch("speed", m_tdata[63:32], oldest.speed);
                end
                if (m_tuser[0] !== oldest.updated) begin
                    note_mismatch("updated", {31'd0, m_tuser[0]}, {31'd0, oldest.updated});
                end
            end
        end
    end

    // Watchdog: abort when no transfer moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("sampled_speed_pid: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side and register writes
    // ------------------------------------------------------------------------

    // Send one sample. tvalid stays high after the transfer; the next call,
    // an idle cycle or wait_for_results drops or reuses it in the same step.
    task automatic send_sample(input logic [31:0] now_ms, input logic [31:0] rot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rot, now_ms};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_results.push_back(compute_pid_step(now_ms, rot));
        sent_ms  = now_ms;
        sent_rot = rot;
    endtask

    // Hold the input idle until every predicted result has been checked
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [spid_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            spid_pkg::REG_TARGET_SPEED:   tgt_speed = val;
            spid_pkg::REG_SAMPLE_TIME_MS: sample_ms = val[15:0];
            spid_pkg::REG_GAIN_P:         kp        = val;
            spid_pkg::REG_GAIN_I:         ki        = val;
            spid_pkg::REG_GAIN_D:         kd        = val;
            spid_pkg::REG_OUTPUT_SCALE:   out_scale = val[7:0];
            default:                      ;
        endcase
    endtask

    // Rewrite the whole register file; only call while nothing is in flight
    task automatic set_registers(input logic [31:0] target, input logic [31:0] sample,
                                 input logic [31:0] gp, input logic [31:0] gi,
                                 input logic [31:0] gd, input logic [31:0] scale);
        write_reg(spid_pkg::REG_TARGET_SPEED,   target);
        write_reg(spid_pkg::REG_SAMPLE_TIME_MS, sample);
        write_reg(spid_pkg::REG_GAIN_P,         gp);
        write_reg(spid_pkg::REG_GAIN_I,         gi);
        write_reg(spid_pkg::REG_GAIN_D,         gd);
        write_reg(spid_pkg::REG_OUTPUT_SCALE,   scale);
        cfg_we <= 1'b0;
    endtask

    // Mostly small gains around unity, now and then anything
    function automatic logic [31:0] pick_gain();
        if ($urandom_range(4) == 0) begin
            return $urandom;
        end
        return int'($urandom_range(262143)) - 131072;
    endfunction

    task automatic randomize_registers();
        logic [31:0] target, sample;
        case ($urandom_range(3))
            0:       target = $urandom;
            default: target = int'($urandom_range(1048575)) - 524288;
        endcase
        case ($urandom_range(7))
            0:       sample = $urandom_range(65535, 1);
            1:       sample = 32'd65535;
            default: sample = $urandom_range(1000, 1);
        endcase
        set_registers(target, sample, pick_gain(), pick_gain(), pick_gain(),
                      $urandom_range(255));
    endtask

    // Next sample of a plausible stream: timestamps mostly one sample time
    // apart, rotations creeping forward, with jumps, reversals and wraps
    task automatic send_random_sample();
        logic [31:0] st, dt, rot;
        st = (sample_ms == 16'd0) ? 32'd1 : {16'd0, sample_ms};
        case ($urandom_range(19))
            0, 1, 2: dt = $urandom_range(st - 1);
            3:       dt = $urandom;
            default: dt = st + $urandom_range(st / 2);
        endcase
        case ($urandom_range(19))
            0:       rot = $urandom;
            1:       rot = -sent_rot;
            2:       rot = 32'h8000_0000;
            3:       rot = 32'h7FFF_FFFF;
            default: rot = sent_rot + (int'($urandom_range(327680)) - 32768);
        endcase
        send_sample(sent_ms + dt, rot);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults: 500 ms sample time, zero gains, scale of four
    task automatic test_reset_defaults();
        send_sample(32'd0,    32'h0000_0000);   // no time elapsed
        send_sample(32'd499,  32'h0001_0000);   // one ms short
        send_sample(32'd500,  32'h0002_0000);   // exactly the sample time
        send_sample(32'd1000, 32'h7FFF_FFFF);
        send_sample(32'd1500, 32'h8000_0000);   // most negative rotation count
        wait_for_results();
    endtask

    // Saturation everywhere, timestamp wrap, zero sample time
    task automatic test_extremes();
        set_registers(32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'd255);
        send_sample(32'd1501,      32'hFFFF_0000);  // negative count, stored raw
        send_sample(32'd1501,      32'h0001_0000);  // zero elapsed
        send_sample(32'd1502,      32'h0001_0000);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF);  // huge elapsed
        send_sample(32'd4,         32'h8000_0000);  // timestamp wraps
        wait_for_results();

        set_registers(32'h8000_0000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'd0);
        send_sample(32'd4, 32'h0000_0000);          // zero sample time acts as one
        send_sample(32'd5, 32'hFFFF_FFFF);
        send_sample(32'd6, 32'h0000_8000);
        wait_for_results();
    endtask

    // Longest sample time; upper data bits of the 16-bit register are junk
    task automatic test_long_sample_time();
        set_registers(32'h0003_0000, 32'hABCD_FFFF, 32'h0000_8000, 32'h0000_1000,
                      32'h0002_0000, 32'd255);
        send_sample(32'd6 + 32'd65534, 32'h0010_0000);  // one ms short
        send_sample(32'd6 + 32'd65535, 32'h0020_0000);
        send_sample(32'd6 + 32'd65535 + 32'd66000, 32'h0030_0000);
        wait_for_results();
    endtask

    // Random stream under one idle profile, two register settings per run;
    // the drain between halves doubles as a full pause of the sender
    task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                       input int unsigned count);
        int unsigned i;
        send_idle_pct = idle;
        stall_pct     = stall;
        randomize_registers();
        for (i = 0; i < count; i++) begin
            if (i == count / 2) begin
                wait_for_results();
                randomize_registers();
            end
            send_random_sample();
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_extremes();
        test_long_sample_time();
        test_random_traffic(0,  0,  110);
        test_random_traffic(83, 0,  110);
        test_random_traffic(0,  83, 110);
        test_random_traffic(17, 17, 110);

        // let any stray result surface before the verdict
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("sampled_speed_pid: match");
        end else begin
            $display("sampled_speed_pid: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/spid_pkg.sv
rtl/spid_mul.sv
rtl/spid_div.sv
rtl/sampled_speed_pid.sv
sim/sampled_speed_pid_tb.sv
